/* rtl/core/cbs_pkg.sv */
// Package for the configurable byte-stream CRC engine.
// Holds the configuration register indexes, reset values and the configuration record type.
// No dependencies.
package cbs_pkg;

    localparam int MAX_WIDTH_DEF = 64;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int CRC_WIDTH_W   = 7;
    localparam int BYTE_W        = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC_WIDTH      = 3'd0,
        CFG_POLYNOMIAL     = 3'd1,
        CFG_SEED_VALUE     = 3'd2,
        CFG_FINAL_XOR      = 3'd3,
        CFG_REFLECT_INPUT  = 3'd4,
        CFG_REFLECT_RESULT = 3'd5
    } cfg_idx_t;

    localparam logic [CRC_WIDTH_W-1:0] RST_CRC_WIDTH     = 7'd32;
    localparam logic [CFG_DATA_W-1:0]  RST_POLYNOMIAL    = 64'h0000_0000_04C1_1DB7;
    localparam logic [CFG_DATA_W-1:0]  RST_SEED_VALUE    = 64'h0000_0000_FFFF_FFFF;
    localparam logic [CFG_DATA_W-1:0]  RST_FINAL_XOR     = 64'h0000_0000_FFFF_FFFF;
    localparam logic                   RST_REFLECT_IN    = 1'b1;
    localparam logic                   RST_REFLECT_OUT   = 1'b1;

    typedef struct packed {
        logic [CRC_WIDTH_W-1:0] crc_width;
        logic [CFG_DATA_W-1:0]  polynomial;
        logic [CFG_DATA_W-1:0]  seed_value;
        logic [CFG_DATA_W-1:0]  final_xor;
        logic                   reflect_input;
        logic                   reflect_result;
    } cfg_t;

endpackage

/* rtl/core/configurable_crc_byte_stream_top.sv */
// A beat accepted goes into the input register and moves on to the output register once the
// output side is free. One byte per cycle while out_stall does not block the output; the eight
// shift-and-XOR steps and CRC register update sit in the single stage between the two registers.
// Reset: rst_n clears both pipeline valid flags, restores the configuration reset values
// and loads the CRC register with the reset seed value.
// Top level of the configurable byte-stream CRC engine; uses cbs_pkg, cbs_cfg and cbs_core.
module configurable_crc_byte_stream_top #(
    parameter int MAX_WIDTH = cbs_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [cbs_pkg::BYTE_W-1:0]        data_byte,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cbs_pkg::CFG_DATA_W-1:0]    crc_value
);

    cbs_pkg::cfg_t                   cfg;
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic [cbs_pkg::BYTE_W-1:0]      s1_byte_reg;
    logic                            s1_restart_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [cbs_pkg::CFG_DATA_W-1:0]  crc_value_reg;
    logic [MAX_WIDTH-1:0]            crc_reg;
    logic [MAX_WIDTH-1:0]            crc_next;
    logic [cbs_pkg::CFG_DATA_W-1:0]  result;
    logic                            out_free;
    logic                            s1_adv;
    logic                            in_take;

    cbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cbs_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .cfg       (cfg),
        .crc_reg   (crc_reg),
        .data_byte (s1_byte_reg),
        .restart   (s1_restart_reg),
        .crc_next  (crc_next),
        .crc_value (result)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign crc_value = crc_value_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= MAX_WIDTH'(cbs_pkg::RST_SEED_VALUE);
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                crc_reg <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg    <= data_byte;
            s1_restart_reg <= restart;
        end
        if (s1_adv)
        begin
            crc_value_reg <= result;
        end
    end

`ifndef SYNTHESIS
    // A beat held in the input register stays there until the output side frees up.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg)
        else $error("input stage dropped a beat while the output was blocked");

    // The input side is stalled only while the input register holds a beat.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    // A beat moving out of the input register always shows up at the output.
    a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced beat did not reach the output register");

    // The CRC register changes only when a beat is processed.
    a_crc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(crc_reg))
        else $error("CRC register changed without a beat");
`endif

endmodule

/* rtl/core/cbs_cfg.sv */
// Configuration register file of the byte-stream CRC engine.
// Depends on cbs_pkg for the register indexes, reset values and cfg_t.
module cbs_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]    cfg_data,
    output cbs_pkg::cfg_t                     cfg
);

    cbs_pkg::cfg_t cfg_reg;
    cbs_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cbs_pkg::cfg_idx_t'(cfg_index))
                cbs_pkg::CFG_CRC_WIDTH:
                    cfg_next.crc_width = cfg_data[cbs_pkg::CRC_WIDTH_W-1:0];
                cbs_pkg::CFG_POLYNOMIAL:     cfg_next.polynomial     = cfg_data;
                cbs_pkg::CFG_SEED_VALUE:     cfg_next.seed_value     = cfg_data;
                cbs_pkg::CFG_FINAL_XOR:      cfg_next.final_xor      = cfg_data;
                cbs_pkg::CFG_REFLECT_INPUT:  cfg_next.reflect_input  = cfg_data[0];
                cbs_pkg::CFG_REFLECT_RESULT: cfg_next.reflect_result = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_width      <= cbs_pkg::RST_CRC_WIDTH;
            cfg_reg.polynomial     <= cbs_pkg::RST_POLYNOMIAL;
            cfg_reg.seed_value     <= cbs_pkg::RST_SEED_VALUE;
            cfg_reg.final_xor      <= cbs_pkg::RST_FINAL_XOR;
            cfg_reg.reflect_input  <= cbs_pkg::RST_REFLECT_IN;
            cfg_reg.reflect_result <= cbs_pkg::RST_REFLECT_OUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/cbs_core.sv */
// Combinational byte update of the CRC engine: aligns the register to the top bit,
// runs eight shift-and-XOR steps and forms the finished CRC. Depends on cbs_pkg.
module cbs_core #(
    parameter int MAX_WIDTH = cbs_pkg::MAX_WIDTH_DEF
) (
    input  cbs_pkg::cfg_t                   cfg,
    input  logic [MAX_WIDTH-1:0]            crc_reg,
    input  logic [cbs_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            restart,
    output logic [MAX_WIDTH-1:0]            crc_next,
    output logic [cbs_pkg::CFG_DATA_W-1:0]  crc_value
);

    localparam logic [cbs_pkg::CRC_WIDTH_W-1:0] MaxW = cbs_pkg::CRC_WIDTH_W'(MAX_WIDTH);
    localparam logic [cbs_pkg::CRC_WIDTH_W-1:0] MinW = cbs_pkg::CRC_WIDTH_W'(cbs_pkg::BYTE_W);

    logic [cbs_pkg::CRC_WIDTH_W-1:0] eff_w;
    logic [cbs_pkg::CRC_WIDTH_W-1:0] shift;
    logic [MAX_WIDTH-1:0]            mask;
    logic [MAX_WIDTH-1:0]            poly_al;
    logic [MAX_WIDTH-1:0]            start;
    logic [MAX_WIDTH-1:0]            acc;
    logic [MAX_WIDTH-1:0]            acc_rev;
    logic [MAX_WIDTH-1:0]            result;
    logic [cbs_pkg::BYTE_W-1:0]      msg;
    logic                            fb;

    always_comb
    begin
        if (cfg.crc_width < MinW)
        begin
            eff_w = MinW;
        end
        else if (cfg.crc_width > MaxW)
        begin
            eff_w = MaxW;
        end
        else
        begin
            eff_w = cfg.crc_width;
        end
        shift = MaxW - eff_w;
        mask  = {MAX_WIDTH{1'b1}} >> shift;
    end

    // Values are shifted up so that the CRC's top bit is always bit MAX_WIDTH-1.
    always_comb
    begin
        poly_al = cfg.polynomial[MAX_WIDTH-1:0] << shift;
        if (restart)
        begin
            start = cfg.seed_value[MAX_WIDTH-1:0] << shift;
        end
        else
        begin
            start = crc_reg << shift;
        end
        for (int b = 0; b < cbs_pkg::BYTE_W; b++)
        begin
            msg[b] = cfg.reflect_input ? data_byte[cbs_pkg::BYTE_W-1-b] : data_byte[b];
        end
        acc = start;
        for (int i = cbs_pkg::BYTE_W - 1; i >= 0; i--)
        begin
            fb  = acc[MAX_WIDTH-1] ^ msg[i];
            acc = acc << 1;
            if (fb)
            begin
                acc = acc ^ poly_al;
            end
        end
    end

    // The full reversal of the aligned register is the mirror over the width.
    always_comb
    begin
        for (int k = 0; k < MAX_WIDTH; k++)
        begin
            acc_rev[k] = acc[MAX_WIDTH-1-k];
        end
        crc_next = acc >> shift;
        result   = cfg.reflect_result ? acc_rev : crc_next;
        result   = (result ^ cfg.final_xor[MAX_WIDTH-1:0]) & mask;
    end

    assign crc_value = cbs_pkg::CFG_DATA_W'(result);

endmodule

/* verif/configurable_crc_byte_stream_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the configurable byte-stream CRC engine top level.
// Walks a directed stimulus table, then random byte streams under many CRC setups.
// Depends on cbs_pkg and configurable_crc_byte_stream_top.
module configurable_crc_byte_stream_top_test;

    localparam logic [cbs_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [cbs_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int DIRECTED_ROWS = 39;
    localparam int BLOCK_BEATS = 100;

    typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [cbs_pkg::CFG_IDX_W-1:0]   index;
        logic [cbs_pkg::CFG_DATA_W-1:0]  value;
        logic [cbs_pkg::BYTE_W-1:0]      data;
        logic                            new_msg;
        logic                            checked;
        logic [cbs_pkg::CFG_DATA_W-1:0]  crc;
    } stim_row_t;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_BEAT,  '0, 64'h0, 8'h00, 1'b1, 1'b1, 64'hD202_EF8D},
        '{ROW_BEAT,  '0, 64'h0, 8'hFF, 1'b1, 1'b1, 64'hFF00_0000},
        '{ROW_BEAT,  '0, 64'h0, 8'h31, 1'b1, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'h32, 1'b0, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'h33, 1'b0, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'h34, 1'b0, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'h35, 1'b0, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'h36, 1'b0, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'h37, 1'b0, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'h38, 1'b0, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'h39, 1'b0, 1'b1, 64'hCBF4_3926},
        '{ROW_WRITE, cbs_pkg::CFG_CRC_WIDTH, 64'h0, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_POLYNOMIAL, 64'hFFFF_FFFF_FFFF_FF07, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_SEED_VALUE, 64'h0, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_FINAL_XOR, 64'h0, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_REFLECT_INPUT, 64'h0, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_REFLECT_RESULT, 64'h0, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'hFF, 1'b1, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'hA5, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_CRC_WIDTH, 64'h7F, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_POLYNOMIAL, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_SEED_VALUE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_REFLECT_INPUT, 64'h1, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'hFF, 1'b1, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'h01, 1'b0, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'h80, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, CFG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, CFG_SPARE_HI, 64'h0, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_REFLECT_RESULT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0,
          64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_REFLECT_INPUT, 64'hFFFF_FFFF_FFFF_FFFE, 8'h00, 1'b0, 1'b0,
          64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'h5A, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_CRC_WIDTH, 64'h11, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'hC3, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_CRC_WIDTH, 64'h40, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_POLYNOMIAL, 64'h0, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'h7E, 1'b1, 1'b0, 64'h0},
        '{ROW_WRITE, cbs_pkg::CFG_CRC_WIDTH, 64'h08, 8'h00, 1'b0, 1'b0, 64'h0},
        '{ROW_BEAT,  '0, 64'h0, 8'h81, 1'b0, 1'b0, 64'h0}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [cbs_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [cbs_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [cbs_pkg::BYTE_W-1:0]      data_byte;
    logic                            restart;
    logic                            out_valid;
    logic                            out_stall;
    logic [cbs_pkg::CFG_DATA_W-1:0]  crc_value;

    cbs_pkg::cfg_t                   crc_setup;
    logic [cbs_pkg::CFG_DATA_W-1:0]  crc_state;
    logic [cbs_pkg::CFG_DATA_W-1:0]  crc_expect_q[$];
    int                              send_idle_pct;
    int                              recv_idle_pct;
    int                              hold_left;
    int                              fail_count;

    configurable_crc_byte_stream_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .crc_value (crc_value)
    );

    function automatic int unsigned active_width(
        input logic [cbs_pkg::CRC_WIDTH_W-1:0] w);
        int unsigned e;
        e = 32'(w);
        if (e < 8)
        begin
            e = 8;
        end
        if (e > cbs_pkg::MAX_WIDTH_DEF)
        begin
            e = cbs_pkg::MAX_WIDTH_DEF;
        end
        return e;
    endfunction

    function automatic logic [cbs_pkg::CFG_DATA_W-1:0] width_mask(input int unsigned w);
        if (w >= 64)
        begin
            return '1;
        end
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic logic [cbs_pkg::CFG_DATA_W-1:0] mirror_bits(
        input logic [cbs_pkg::CFG_DATA_W-1:0] v, input int unsigned w);
        logic [cbs_pkg::CFG_DATA_W-1:0] r;
        r = '0;
        for (int i = 0; i < w; i++)
        begin
            r = {r[cbs_pkg::CFG_DATA_W-2:0], v[i]};
        end
        return r;
    endfunction

    task automatic record_crc_beat(input logic [cbs_pkg::BYTE_W-1:0] msg_byte,
                                   input logic new_msg, input logic use_known,
                                   input logic [cbs_pkg::CFG_DATA_W-1:0] known);
        int unsigned                    w;
        logic [cbs_pkg::CFG_DATA_W-1:0] mask;
        logic [cbs_pkg::CFG_DATA_W-1:0] crc;
        logic [cbs_pkg::CFG_DATA_W-1:0] shaped;
        logic                           feedback;
        w = active_width(crc_setup.crc_width);
        mask = width_mask(w);
        crc = crc_state & mask;
        if (new_msg)
        begin
            crc = crc_setup.seed_value & mask;
        end
        shaped = crc_setup.reflect_input ? mirror_bits(cbs_pkg::CFG_DATA_W'(msg_byte), 8)
                                         : cbs_pkg::CFG_DATA_W'(msg_byte);
        for (int i = 7; i >= 0; i--)
        begin
            feedback = crc[w-1] ^ shaped[i];
            crc = (crc << 1) & mask;
            if (feedback)
            begin
                crc = crc ^ (crc_setup.polynomial & mask);
            end
        end
        crc_state = crc;
        shaped = crc_setup.reflect_result ? mirror_bits(crc, w) : crc;
        crc_expect_q.push_back(use_known ? known : ((shaped ^ crc_setup.final_xor) & mask));
    endtask

    task automatic write_reg(input logic [cbs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cbs_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            cbs_pkg::CFG_CRC_WIDTH:
                crc_setup.crc_width = value[cbs_pkg::CRC_WIDTH_W-1:0];
            cbs_pkg::CFG_POLYNOMIAL:     crc_setup.polynomial = value;
            cbs_pkg::CFG_SEED_VALUE:     crc_setup.seed_value = value;
            cbs_pkg::CFG_FINAL_XOR:      crc_setup.final_xor = value;
            cbs_pkg::CFG_REFLECT_INPUT:  crc_setup.reflect_input = value[0];
            cbs_pkg::CFG_REFLECT_RESULT: crc_setup.reflect_result = value[0];
            default:                     ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic send_beat(input logic [cbs_pkg::BYTE_W-1:0] msg_byte, input logic new_msg,
                             input logic use_known,
                             input logic [cbs_pkg::CFG_DATA_W-1:0] known);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= msg_byte;
        restart   <= new_msg;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        record_crc_beat(msg_byte, new_msg, use_known, known);
    endtask

    task automatic wait_drain;
        in_valid <= 1'b0;
        while (crc_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic random_setup;
        logic [cbs_pkg::CFG_DATA_W-1:0]  noise;
        logic [cbs_pkg::CRC_WIDTH_W-1:0] w;
        wait_drain();
        case ($urandom_range(0, 9))
            0:       w = cbs_pkg::CRC_WIDTH_W'($urandom_range(0, 7));
            1:       w = cbs_pkg::CRC_WIDTH_W'($urandom_range(65, 127));
            2:       w = cbs_pkg::CRC_WIDTH_W'(8);
            3:       w = cbs_pkg::CRC_WIDTH_W'(64);
            default: w = cbs_pkg::CRC_WIDTH_W'($urandom_range(8, 64));
        endcase
        noise = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0)
        begin
            write_reg(cbs_pkg::CFG_CRC_WIDTH,
                      {noise[cbs_pkg::CFG_DATA_W-1:cbs_pkg::CRC_WIDTH_W], w});
        end
        if ($urandom_range(0, 3) != 0)
        begin
            write_reg(cbs_pkg::CFG_POLYNOMIAL, {$urandom, $urandom});
        end
        if ($urandom_range(0, 3) != 0)
        begin
            write_reg(cbs_pkg::CFG_SEED_VALUE, {$urandom, $urandom});
        end
        if ($urandom_range(0, 3) != 0)
        begin
            write_reg(cbs_pkg::CFG_FINAL_XOR, {$urandom, $urandom});
        end
        if ($urandom_range(0, 3) != 0)
        begin
            write_reg(cbs_pkg::CFG_REFLECT_INPUT, {$urandom, $urandom});
        end
        if ($urandom_range(0, 3) != 0)
        begin
            write_reg(cbs_pkg::CFG_REFLECT_RESULT, {$urandom, $urandom});
        end
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, {$urandom, $urandom});
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [cbs_pkg::CFG_DATA_W-1:0] want;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (crc_expect_q.size() == 0)
                begin
                    $error("crc_value: beat with nothing expected, actual %h", crc_value);
                    fail_count++;
                end
                else
                begin
                    want = crc_expect_q.pop_front();
                    if (crc_value !== want)
                    begin
                        $error("crc_value mismatch: expected %h, actual %h", want, crc_value);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    initial
    begin
        int guard;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        data_byte = '0;
        restart = 1'b0;
        fail_count = 0;
        hold_left = 0;
        send_idle_pct = 8;
        recv_idle_pct = 83;
        crc_setup = '{cbs_pkg::RST_CRC_WIDTH, cbs_pkg::RST_POLYNOMIAL, cbs_pkg::RST_SEED_VALUE,
                      cbs_pkg::RST_FINAL_XOR, cbs_pkg::RST_REFLECT_IN, cbs_pkg::RST_REFLECT_OUT};
        crc_state = cbs_pkg::RST_SEED_VALUE & width_mask(32);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_WRITE)
            begin
                wait_drain();
                write_reg(DIRECTED[r].index, DIRECTED[r].value);
            end
            else
            begin
                send_beat(DIRECTED[r].data, DIRECTED[r].new_msg, DIRECTED[r].checked,
                          DIRECTED[r].crc);
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 83 : 0;
            recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 8 : 0;
            for (int blk = 0; blk < 5; blk++)
            begin
                random_setup();
                if (phase == 2 && blk == 0)
                begin
                    hold_left = 300;
                end
                for (int n = 0; n < BLOCK_BEATS; n++)
                begin
                    if (phase == 1 && blk == 2 && n == BLOCK_BEATS / 2)
                    begin
                        wait_drain();
                    end
                    send_beat(cbs_pkg::BYTE_W'($urandom_range(0, 255)),
                              (n == 0) ? 1'($urandom_range(0, 1))
                                       : ($urandom_range(0, 7) == 0),
                              1'b0, '0);
                end
            end
        end

        in_valid <= 1'b0;
        guard = 0;
        while (crc_expect_q.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (crc_expect_q.size() != 0)
        begin
            $error("crc_value: %0d expected beats never arrived", crc_expect_q.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
